@@ design/dsi_pkg.sv @@
// Shared constants and types for the descending sorted insert block.
// Depends on nothing; the top level takes everything here by scoped name.
package dsi_pkg;

  localparam int CAPACITY = 32;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         cnt_t;

endpackage

@@ design/descending_sorted_insert.sv @@
// Descending sorted insert: load items are placed into a store kept largest first;
// an insert item is placed likewise, then every entry streams out and the store clears.
// A load item is written straight into an empty store; otherwise the entries smaller than it are
// read and shifted one place down, one read and one write of the single store memory a cycle.
// Each result is then read, loaded into the output register and held until the handshake.
// Reset (rst_n low, synchronous) empties the store and clears the overflow flag.
module descending_sorted_insert (
  input  logic        clk,
  input  logic        rst_n,
  // Input beat.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tuser,   // [0] is_insert
  // Result beat.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] sorted_value
  output logic        out_tlast,  // last
  output logic        out_tuser   // [0] overflow
);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_CMP       = 3'd1;
  localparam logic [2:0] ST_WRITE     = 3'd2;
  localparam logic [2:0] ST_EMIT_RD   = 3'd3;
  localparam logic [2:0] ST_EMIT_LD   = 3'd4;
  localparam logic [2:0] ST_EMIT_WAIT = 3'd5;

  localparam dsi_pkg::cnt_t CNT_FULL = dsi_pkg::cnt_t'(dsi_pkg::CAPACITY);
  localparam dsi_pkg::cnt_t CNT_ONE  = dsi_pkg::cnt_t'(1);

  // Store memory with registered read.
  dsi_pkg::data_t mem [dsi_pkg::CAPACITY];
  dsi_pkg::data_t rd_data_r;
  logic           rd_en;
  dsi_pkg::addr_t rd_addr;
  logic           wr_en;
  dsi_pkg::addr_t wr_addr;
  dsi_pkg::data_t wr_data;

  // Control and payload registers.
  logic [2:0]     state_r, state_nxt;
  dsi_pkg::cnt_t  count_r, count_nxt;
  dsi_pkg::cnt_t  pos_r, pos_nxt;
  dsi_pkg::addr_t k_r, k_nxt;
  logic           drop_r, drop_nxt;
  dsi_pkg::data_t val_r, val_nxt;
  logic           ins_r, ins_nxt;
  logic           out_valid_r, out_valid_nxt;
  dsi_pkg::data_t out_data_r, out_data_nxt;
  logic           out_last_r, out_last_nxt;
  logic           out_ovf_r, out_ovf_nxt;

  logic           in_fire;
  dsi_pkg::cnt_t  pos_m1;
  dsi_pkg::cnt_t  pos_m2;
  dsi_pkg::cnt_t  cnt_m1;
  dsi_pkg::cnt_t  k_ext;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

  assign pos_m1 = pos_r - CNT_ONE;
  assign pos_m2 = pos_r - dsi_pkg::cnt_t'(2);
  assign cnt_m1 = count_r - CNT_ONE;
  assign k_ext  = dsi_pkg::cnt_t'(k_r);

  // Sequence placement and emission.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    k_nxt         = k_r;
    drop_nxt      = drop_r;
    val_nxt       = val_r;
    ins_nxt       = ins_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = pos_r[dsi_pkg::ADDR_W-1:0];
    wr_data       = val_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          val_nxt = dsi_pkg::data_t'(in_tdata);
          ins_nxt = in_tuser;
          pos_nxt = count_r;
          if (count_r == CNT_FULL) begin
            // Drop the value; an insert still emits the full store.
            drop_nxt  = 1'b1;
            k_nxt     = '0;
            state_nxt = in_tuser ? ST_EMIT_RD : ST_IDLE;
          end else if (count_r == '0) begin
            state_nxt = ST_WRITE;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = cnt_m1[dsi_pkg::ADDR_W-1:0];
            state_nxt = ST_CMP;
          end
        end
      end

      ST_CMP: begin
        wr_en = 1'b1;
        if (rd_data_r < val_r) begin
          // Move the smaller entry one place down and look one higher.
          wr_data = rd_data_r;
          pos_nxt = pos_m1;
          if (pos_r == CNT_ONE) begin
            state_nxt = ST_WRITE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = pos_m2[dsi_pkg::ADDR_W-1:0];
          end
        end else begin
          count_nxt = count_r + CNT_ONE;
          k_nxt     = '0;
          state_nxt = ins_r ? ST_EMIT_RD : ST_IDLE;
        end
      end

      ST_WRITE: begin
        wr_en     = 1'b1;
        count_nxt = count_r + CNT_ONE;
        k_nxt     = '0;
        state_nxt = ins_r ? ST_EMIT_RD : ST_IDLE;
      end

      ST_EMIT_RD: begin
        rd_en     = 1'b1;
        rd_addr   = k_r;
        state_nxt = ST_EMIT_LD;
      end

      ST_EMIT_LD: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = rd_data_r;
        out_last_nxt  = (k_ext == cnt_m1);
        out_ovf_nxt   = drop_r;
        state_nxt     = ST_EMIT_WAIT;
      end

      ST_EMIT_WAIT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            // Run complete: empty the store.
            count_nxt = '0;
            drop_nxt  = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + dsi_pkg::addr_t'(1);
            state_nxt = ST_EMIT_RD;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Store memory: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    k_r        <= k_nxt;
    val_r      <= val_nxt;
    ins_r      <= ins_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

endmodule

@@ tb/sv/descending_sorted_insert_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for descending_sorted_insert: directed table, then random runs.
// Depends on dsi_pkg and the block itself; each run is checked against a local predictor.
module descending_sorted_insert_tb;

  localparam dsi_pkg::data_t VMAX     = 32'sh7FFF_FFFF;
  localparam dsi_pkg::data_t VMIN     = 32'sh8000_0000;
  localparam int    NUM_DIR           = 23;
  localparam int    PHASE_ITEMS       = 67;
  localparam int    LONG_HOLD         = 300;
  localparam int    DRAIN_CYCLES      = 3 * dsi_pkg::CAPACITY + 8;
  localparam int    NO_PROGRESS_LIMIT = 2000;
  localparam int    MAX_REPORTS       = 10;

  typedef struct packed {
    dsi_pkg::data_t value;
    logic           last;
    logic           overflow;
  } result_t;

  // Directed row; typed rows carry a single-beat run whose value is read off directly.
  typedef struct packed {
    dsi_pkg::data_t value;
    logic           is_ins;
    logic           typed;
    dsi_pkg::data_t exp_value;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] value
  logic        in_tuser;   // [0] is_insert
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] sorted_value
  logic        out_tlast;
  logic        out_tuser;  // [0] overflow

  // Predictor state: ranked copy of the store, fill level and dropped marker.
  dsi_pkg::data_t shadow_rank [dsi_pkg::CAPACITY];
  int             shadow_fill;
  logic           shadow_overflow;
  result_t        expected_sorted [$];

  int mismatches;
  int snd_idle_pct;
  int rcv_idle_pct;
  bit long_hold_req;
  int stall_cycles = 0;

  dir_row_t dir_table [NUM_DIR] = '{
    '{VMAX,  1'b1, 1'b1, VMAX},
    '{VMIN,  1'b1, 1'b1, VMIN},
    '{32'sd0, 1'b1, 1'b1, 32'sd0},
    '{-32'sd1, 1'b1, 1'b1, -32'sd1},
    '{VMIN,  1'b0, 1'b0, 32'sd0},
    '{VMAX,  1'b0, 1'b0, 32'sd0},
    '{32'sd0, 1'b0, 1'b0, 32'sd0},
    '{-32'sd1, 1'b0, 1'b0, 32'sd0},
    '{32'sd5, 1'b0, 1'b0, 32'sd0},
    '{32'sd5, 1'b0, 1'b0, 32'sd0},
    '{-32'sd5, 1'b0, 1'b0, 32'sd0},
    '{32'sd5, 1'b1, 1'b0, 32'sd0},
    '{32'sh5555_5555, 1'b0, 1'b0, 32'sd0},
    '{32'shAAAA_AAAA, 1'b0, 1'b0, 32'sd0},
    '{32'sd1, 1'b1, 1'b0, 32'sd0},
    '{32'sd1, 1'b0, 1'b0, 32'sd0},
    '{32'sd2, 1'b0, 1'b0, 32'sd0},
    '{32'sd3, 1'b0, 1'b0, 32'sd0},
    '{32'sd4, 1'b1, 1'b0, 32'sd0},
    '{32'sd3, 1'b0, 1'b0, 32'sd0},
    '{32'sd2, 1'b0, 1'b0, 32'sd0},
    '{32'sd1, 1'b0, 1'b0, 32'sd0},
    '{32'sd0, 1'b1, 1'b0, 32'sd0}
  };

  descending_sorted_insert u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #2 clk = ~clk;

  // Place one value largest first; on an insert, queue the whole run and empty the store.
  function automatic void predict_sorted_run(input dsi_pkg::data_t v, input logic is_ins,
                                             input bit keep);
    int      pos;
    int      k;
    result_t r;
    if (shadow_fill >= dsi_pkg::CAPACITY) begin
      shadow_overflow = 1'b1;
    end else begin
      pos = shadow_fill;
      while (pos > 0 && shadow_rank[pos-1] < v) begin
        shadow_rank[pos] = shadow_rank[pos-1];
        pos--;
      end
      shadow_rank[pos] = v;
      shadow_fill++;
    end
    if (is_ins) begin
      if (keep) begin
        for (k = 0; k < shadow_fill; k++) begin
          r.value    = shadow_rank[k];
          r.last     = (k == shadow_fill - 1);
          r.overflow = shadow_overflow;
          expected_sorted.push_back(r);
        end
      end
      shadow_fill     = 0;
      shadow_overflow = 1'b0;
    end
  endfunction

  function automatic dsi_pkg::data_t rand_value();
    case ($urandom_range(0, 7))
      0: return $signed($urandom_range(0, 8)) - 4;
      1: begin
        case ($urandom_range(0, 3))
          0: return VMAX;
          1: return VMIN;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      2: return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // Mostly short runs, some mid-sized, some that reach or pass a full store.
  function automatic int pick_run_length();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(0, 6);
      6, 7: return $urandom_range(7, dsi_pkg::CAPACITY - 2);
      default: return $urandom_range(dsi_pkg::CAPACITY - 1, dsi_pkg::CAPACITY + 3);
    endcase
  endfunction

  // Offer one beat, idling first at random; update the predictor once it is taken.
  task automatic send_item(input dsi_pkg::data_t v, input logic is_ins, input bit typed,
                           input dsi_pkg::data_t typed_value);
    result_t r;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tuser  <= is_ins;
    do @(posedge clk); while (!in_tready);
    predict_sorted_run(v, is_ins, !typed);
    if (typed) begin
      r.value    = typed_value;
      r.last     = 1'b1;
      r.overflow = 1'b0;
      expected_sorted.push_back(r);
    end
  endtask

  task automatic send_run(input int loads);
    int i;
    for (i = 0; i < loads; i++) begin
      send_item(rand_value(), 1'b0, 1'b0, 32'sd0);
    end
    send_item(rand_value(), 1'b1, 1'b0, 32'sd0);
  endtask

  task automatic random_phase(input int forced_loads);
    int sent;
    int n;
    send_run(forced_loads);
    sent = forced_loads + 1;
    while (sent < PHASE_ITEMS) begin
      n = pick_run_length();
      send_run(n);
      sent += n + 1;
    end
  endtask

  task automatic report_mismatch(input string what, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t: %s: expected value %h last %b ovf %b, got value %h last %b ovf %b",
               $realtime, what, want.value, want.last, want.overflow,
               got.value, got.last, got.overflow);
    end
  endtask

  // Check every accepted result beat against the oldest pending expectation.
  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.value    = out_tdata;
      got.last     = out_tlast;
      got.overflow = out_tuser;
      if (expected_sorted.size() == 0) begin
        want = '0;
        report_mismatch("result with nothing pending", want, got);
      end else begin
        want = expected_sorted.pop_front();
        if (got.value !== want.value || got.last !== want.last ||
            got.overflow !== want.overflow) begin
          report_mismatch("result mismatch", want, got);
        end
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold on request.
  initial begin : receiver
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end
      out_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  // Watchdog: end the run if no beat moves on either side for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= NO_PROGRESS_LIMIT) begin
      $display("descending_sorted_insert_tb failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    int i;
    result_t none;
    mismatches      = 0;
    long_hold_req   = 1'b0;
    shadow_fill     = 0;
    shadow_overflow = 1'b0;
    snd_idle_pct    = 13;
    rcv_idle_pct    = 80;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: extremes, empty-store inserts, ties, bit patterns, shift orders.
    for (i = 0; i < NUM_DIR; i++) begin
      send_item(dir_table[i].value, dir_table[i].is_ins, dir_table[i].typed,
                dir_table[i].exp_value);
    end

    // Sender light, receiver heavy; open with a store filled right up before the insert.
    random_phase(dsi_pkg::CAPACITY);

    // Sender heavy, receiver light; open with drops both on load and on insert.
    snd_idle_pct = 80;
    rcv_idle_pct = 13;
    random_phase(dsi_pkg::CAPACITY + 2);

    // No idling; hold the receiver off so the block backs up onto its input.
    snd_idle_pct  = 0;
    rcv_idle_pct  = 0;
    long_hold_req = 1'b1;
    random_phase(4);

    in_tvalid <= 1'b0;
    while (expected_sorted.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    // Anything still pending counts against the run.
    none = '0;
    while (expected_sorted.size() != 0) begin
      report_mismatch("result never arrived", expected_sorted.pop_front(), none);
    end

    if (mismatches == 0) begin
      $display("descending_sorted_insert_tb passed");
    end else begin
      $display("descending_sorted_insert_tb failed");
    end
    $finish;
  end

endmodule
